// File: rtl/ascii_integer_parser_top_assert.svh
// Assertion macros used by the checker file of the block.
`ifndef ASCII_INTEGER_PARSER_TOP_ASSERT_SVH
`define ASCII_INTEGER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aip_pkg.sv
`timescale 1ns / 1ps
package aip_pkg;

  localparam int unsigned CH_W           = 8;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned HEX_MAX_DIGITS = 8;
  localparam int unsigned BIN_MAX_DIGITS = 32;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UB    = 8'h42;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LB    = 8'h62;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SIGN  = 3'd1,
    PH_ZERO  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4,
    PH_BIN   = 3'd5,
    PH_ERR   = 3'd6
  } aip_phase_e;

  typedef struct packed {
    logic               is_nul;
    logic               is_minus;
    logic               is_zero;
    logic               is_dec;
    logic               is_hex;
    logic               is_bin;
    logic               is_x;
    logic               is_b;
    logic [DIGIT_W-1:0] digit;
  } aip_char_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } aip_result_t;

endpackage

// File: rtl/aip_char_decode.sv
`timescale 1ns / 1ps
module aip_char_decode
  import aip_pkg::*;
(
  input  logic [CH_W-1:0] ch_i,
  output aip_char_t       cls_o
);

  logic dec;
  logic lower_hex;
  logic upper_hex;

  always_comb begin
    dec       = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    lower_hex = (ch_i >= CH_LA) && (ch_i <= CH_LF);
    upper_hex = (ch_i >= CH_UA) && (ch_i <= CH_UF);

    cls_o.is_nul   = (ch_i == CH_NUL);
    cls_o.is_minus = (ch_i == CH_MINUS);
    cls_o.is_zero  = (ch_i == CH_ZERO);
    cls_o.is_dec   = dec;
    cls_o.is_hex   = dec || lower_hex || upper_hex;
    cls_o.is_bin   = (ch_i == CH_ZERO) || (ch_i == CH_ONE);
    cls_o.is_x     = (ch_i == CH_LX) || (ch_i == CH_UX);
    cls_o.is_b     = (ch_i == CH_LB) || (ch_i == CH_UB);
    // Digits and letters both carry their value in the low nibble, letters offset by nine.
    cls_o.digit    = dec ? ch_i[DIGIT_W-1:0] : (ch_i[DIGIT_W-1:0] + LETTER_OFFSET);
  end

endmodule

// File: rtl/aip_parse_core.sv
`timescale 1ns / 1ps
module aip_parse_core
  import aip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  aip_char_t   cls_i,
  output logic        res_valid_o,
  output aip_result_t res_o
);

  aip_phase_e         phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               hex_room;
  logic               bin_room;
  logic [VALUE_W-1:0] digit_ext;
  logic [VALUE_W-1:0] acc_times_ten;
  logic               good;

  always_comb begin
    hex_room      = cnt_q < CNT_W'(HEX_MAX_DIGITS);
    bin_room      = cnt_q < CNT_W'(BIN_MAX_DIGITS);
    digit_ext     = VALUE_W'(cls_i.digit);
    acc_times_ten = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0};
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (cls_i.is_nul) begin
        phase_d = PH_START;
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (cls_i.is_minus) begin
              phase_d = PH_SIGN;
            end else if (cls_i.is_zero) begin
              phase_d = PH_ZERO;
            end else if (cls_i.is_dec) begin
              phase_d = PH_DEC;
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_SIGN: begin
            if (cls_i.is_zero) begin
              phase_d = PH_ZERO;
            end else if (cls_i.is_dec) begin
              phase_d = PH_DEC;
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_ZERO: begin
            if (cls_i.is_x) begin
              phase_d = PH_HEX;
            end else if (cls_i.is_b) begin
              phase_d = PH_BIN;
            end else if (cls_i.is_dec) begin
              phase_d = PH_DEC;
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_DEC: begin
            if (!cls_i.is_dec) begin
              phase_d = PH_ERR;
            end
          end
          PH_HEX: begin
            if (!(cls_i.is_hex && hex_room)) begin
              phase_d = PH_ERR;
            end
          end
          PH_BIN: begin
            if (!(cls_i.is_bin && bin_room)) begin
              phase_d = PH_ERR;
            end
          end
          default: begin
            phase_d = PH_ERR;
          end
        endcase
      end
    end
  end

  // Accumulator, sign, digit count and the result at the end of a string.
  always_comb begin
    neg_d = neg_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (cls_i.is_nul) begin
        neg_d = 1'b0;
        acc_d = '0;
        cnt_d = '0;
      end else begin
        unique case (phase_q)
          PH_START, PH_SIGN: begin
            if ((phase_q == PH_START) && cls_i.is_minus) begin
              neg_d = 1'b1;
            end else if (cls_i.is_dec && !cls_i.is_zero) begin
              acc_d = digit_ext;
            end
          end
          PH_ZERO: begin
            if (cls_i.is_dec) begin
              acc_d = digit_ext;
            end
          end
          PH_DEC: begin
            if (cls_i.is_dec) begin
              acc_d = acc_times_ten + digit_ext;
            end
          end
          PH_HEX: begin
            if (cls_i.is_hex && hex_room) begin
              acc_d = {acc_q[VALUE_W-5:0], cls_i.digit};
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          PH_BIN: begin
            if (cls_i.is_bin && bin_room) begin
              acc_d = {acc_q[VALUE_W-2:0], cls_i.digit[0]};
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end

    unique case (phase_q)
      PH_SIGN, PH_ZERO, PH_DEC: good = 1'b1;
      PH_HEX, PH_BIN:           good = (cnt_q != '0);
      default:                  good = 1'b0;
    endcase

    res_valid_o = step_i && cls_i.is_nul;
    res_o.ok    = good;
    res_o.value = good ? (neg_q ? (VALUE_W'(0) - acc_q) : acc_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/ascii_integer_parser_top.sv
`timescale 1ns / 1ps
// ASCII integer parser.
// The slave stream carries one ASCII character per transaction in s_axis_tdata. Characters
// build up a signed decimal, 0x hexadecimal or 0b binary number; a NUL character ends the
// string and causes exactly one transaction on the master stream, carrying the value in
// m_axis_tdata and the success flag in m_axis_tuser. Other characters cause no output.
// Each character is registered on entry and then updates the parser state, so one character is
// taken in every cycle unless a NUL waits for a busy output register. The result of a NUL is
// written to the output register when the NUL leaves the input register and updates the parser.
// When the receiver stalls, the result is held in the output register and characters that
// are not NUL are still accepted; a following NUL waits in the input register, holding
// s_axis_tready low, until the output register is free.
// Reset clears both registers' valid flags and returns the parser to the start of a string.
module ascii_integer_parser_top
  import aip_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [CH_W-1:0]           s_axis_tdata,   // [7:0] ch
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic signed [VALUE_W-1:0] m_axis_tdata,   // [31:0] value
  output logic                      m_axis_tuser    // [0] ok
);

  logic        in_valid_q, in_valid_d;
  logic [CH_W-1:0] ch_q;
  logic        out_valid_q, out_valid_d;
  aip_result_t out_q;

  aip_char_t   cls;
  logic        step;
  logic        out_free;
  logic        in_take;
  logic        res_valid;
  aip_result_t res;

  aip_char_decode u_decode (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  aip_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cls_i       (cls),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    step          = in_valid_q && (!cls.is_nul || out_free);
    s_axis_tready = !in_valid_q || step;
    in_take       = s_axis_tvalid && s_axis_tready;
    in_valid_d    = in_take || (in_valid_q && !step);
    out_valid_d   = res_valid || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= s_axis_tdata;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.ok;

endmodule

// File: rtl/aip_checker.sv
`timescale 1ns / 1ps
`include "ascii_integer_parser_top_assert.svh"
module aip_checker
  import aip_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [CH_W-1:0]           s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic signed [VALUE_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser
);

  `AIP_ASSERT_SAME(a_fail_is_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "A failed parse must give the value zero.")

  `AIP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "A stalled result must be held.")

  `AIP_ASSERT_SAME(a_ready_when_drained, clk_i, rst_ni, m_axis_tready, s_axis_tready, "The input must be ready while the receiver is ready.")

  `AIP_ASSERT_SAME(a_result_from_nul, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_NUL), 2), "A new result must follow an accepted NUL by two cycles.")

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (.*);

// File: tb/aip_result_checker.sv
`timescale 1ns / 1ps
module aip_result_checker
  import aip_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic                      s_ready_i,
  input  logic [CH_W-1:0]           s_data_i,   // [7:0] ch
  input  logic                      m_valid_i,
  input  logic                      m_ready_i,
  input  logic signed [VALUE_W-1:0] m_data_i,   // [31:0] value
  input  logic                      m_user_i,   // [0] ok
  output int                        err_count_o,
  output int                        pending_o
);

  aip_result_t        parsed_q[$];
  aip_result_t        want;
  aip_phase_e         parse_phase;
  logic               is_neg;
  logic [VALUE_W-1:0] acc;
  logic [CNT_W-1:0]   digit_cnt;
  logic [VALUE_W-1:0] digit;
  logic [3:0]         hex_digit;
  logic               hex_hit;
  logic               dec_hit;
  logic               good;
  int                 errs;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parsed_q.delete();
      parse_phase = PH_START;
      is_neg      = 1'b0;
      acc         = '0;
      digit_cnt   = '0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      errs = 0;
      if (m_valid_i && m_ready_i) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected result transaction: value %0d ok %0b", m_data_i, m_user_i);
          errs = errs + 1;
        end else begin
          want = parsed_q.pop_front();
          if (m_data_i !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), m_data_i);
            errs = errs + 1;
          end
          if (m_user_i !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, m_user_i);
            errs = errs + 1;
          end
        end
      end

      if (s_valid_i && s_ready_i) begin
        digit   = VALUE_W'(s_data_i - CH_ZERO);
        dec_hit = (s_data_i >= CH_ZERO) && (s_data_i <= CH_NINE);
        hex_hit = 1'b1;
        if (dec_hit) begin
          hex_digit = digit[3:0];
        end else if (s_data_i >= CH_LA && s_data_i <= CH_LF) begin
          hex_digit = 4'(s_data_i - CH_LA + 8'd10);
        end else if (s_data_i >= CH_UA && s_data_i <= CH_UF) begin
          hex_digit = 4'(s_data_i - CH_UA + 8'd10);
        end else begin
          hex_digit = '0;
          hex_hit   = 1'b0;
        end

        if (s_data_i == CH_NUL) begin
          good = (parse_phase == PH_SIGN) || (parse_phase == PH_ZERO) ||
                 (parse_phase == PH_DEC) ||
                 (((parse_phase == PH_HEX) || (parse_phase == PH_BIN)) && (digit_cnt != 0));
          want.ok    = good;
          want.value = good ? (is_neg ? -acc : acc) : '0;
          parsed_q.push_back(want);
          parse_phase = PH_START;
          is_neg      = 1'b0;
          acc         = '0;
          digit_cnt   = '0;
        end else begin
          case (parse_phase)
            PH_START, PH_SIGN: begin
              if (parse_phase == PH_START && s_data_i == CH_MINUS) begin
                is_neg      = 1'b1;
                parse_phase = PH_SIGN;
              end else if (s_data_i == CH_ZERO) begin
                parse_phase = PH_ZERO;
              end else if (dec_hit) begin
                acc         = digit;
                parse_phase = PH_DEC;
              end else begin
                parse_phase = PH_ERR;
              end
            end
            PH_ZERO: begin
              if (s_data_i == CH_LX || s_data_i == CH_UX) begin
                parse_phase = PH_HEX;
              end else if (s_data_i == CH_LB || s_data_i == CH_UB) begin
                parse_phase = PH_BIN;
              end else if (dec_hit) begin
                acc         = digit;
                parse_phase = PH_DEC;
              end else begin
                parse_phase = PH_ERR;
              end
            end
            PH_DEC: begin
              if (dec_hit) begin
                acc = acc * 32'd10 + digit;
              end else begin
                parse_phase = PH_ERR;
              end
            end
            PH_HEX: begin
              if (hex_hit && digit_cnt < HEX_MAX_DIGITS) begin
                acc       = {acc[VALUE_W-5:0], hex_digit};
                digit_cnt = digit_cnt + 1'b1;
              end else begin
                parse_phase = PH_ERR;
              end
            end
            PH_BIN: begin
              if ((s_data_i == CH_ZERO || s_data_i == CH_ONE) &&
                  digit_cnt < BIN_MAX_DIGITS) begin
                acc       = {acc[VALUE_W-2:0], s_data_i[0]};
                digit_cnt = digit_cnt + 1'b1;
              end else begin
                parse_phase = PH_ERR;
              end
            end
            default: begin
              parse_phase = PH_ERR;
            end
          endcase
        end
      end
      err_count_o <= err_count_o + errs;
      pending_o   <= parsed_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import aip_pkg::*;

  localparam int CHAR_TARGET = 1550;
  localparam int CYCLE_LIMIT = 600000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [CH_W-1:0]           s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic signed [VALUE_W-1:0] m_axis_tdata;
  logic                      m_axis_tuser;

  int              fail_count;
  int              pending;
  int              char_count;
  int              cycle_count;
  logic            no_idle;
  logic [CH_W-1:0] text_q[$];

  ascii_integer_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  aip_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .err_count_o (fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int   hold;
    int   pick;
    logic level;
    m_axis_tready <= 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        level = 1'b1;
        hold  = $urandom_range(1, 8);
      end else if (pick < 85) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else if (pick < 95) begin
        level = 1'b0;
        hold  = $urandom_range(4, 40);
      end else begin
        level = 1'b1;
        hold  = $urandom_range(50, 200);
      end
      m_axis_tready <= level;
      repeat (hold) @(posedge clk_i);
    end
  end

  task automatic send_char(input logic [CH_W-1:0] ch);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 65) begin
      gap = 0;
    end else if (pick < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(4, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    char_count++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CH_NUL);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    string hex_chars;
    int    kind;
    int    len;
    int    pick;
    logic  all_f;
    hex_chars     = "0123456789abcdefABCDEF";
    char_count    = 0;
    no_idle       = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_str("");
    send_str("-");
    send_str("0");
    send_str("-0");
    send_str("0X");
    send_str("0b");
    send_str("--");
    send_str("\3775");
    send_str("7z");
    drain();

    while (char_count < CHAR_TARGET) begin
      if ($urandom_range(0, 149) == 0) drain();
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      text_q.delete();
      if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 4) == 0) text_q.push_back(CH_ZERO);
        len = $urandom_range(1, 12);
        repeat (len) text_q.push_back(CH_W'(CH_ZERO + $urandom_range(0, 9)));
      end else if (kind < 55) begin
        text_q.push_back(CH_ZERO);
        text_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        pick  = $urandom_range(0, 9);
        len   = (pick == 0) ? 0 : (pick == 1) ? 9 : (pick == 2) ? 8 : $urandom_range(1, 8);
        all_f = ($urandom_range(0, 7) == 0);
        repeat (len) begin
          if (all_f) text_q.push_back($urandom_range(0, 1) ? CH_LF : CH_UF);
          else text_q.push_back(hex_chars[$urandom_range(0, 21)]);
        end
      end else if (kind < 75) begin
        text_q.push_back(CH_ZERO);
        text_q.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
        pick = $urandom_range(0, 9);
        len  = (pick == 0) ? 0 : (pick == 1) ? 33 : (pick == 2) ? 32 : $urandom_range(1, 32);
        repeat (len) text_q.push_back(CH_W'(CH_ZERO + $urandom_range(0, 1)));
      end else if (kind < 90) begin
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_LX);
        repeat (3) text_q.push_back(hex_chars[$urandom_range(0, 21)]);
        text_q[$urandom_range(0, text_q.size() - 1)] = CH_W'($urandom_range(1, 255));
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) text_q.push_back(CH_W'($urandom_range(1, 255)));
      end
      send_text();
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
